/* hw/rtl/vwp_pkg.sv */
// Package with the shared types, constants and saturating arithmetic helper of the vertex projector.
package vwp_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned CfgW = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivStages = 8;

  typedef enum logic [CfgIdxW-1:0] {
    RegProjCol0  = 3'd0,
    RegProjCol1  = 3'd1,
    RegProjCol2  = 3'd2,
    RegProjCol3  = 3'd3,
    RegProjRow2A = 3'd4,
    RegProjRow2B = 3'd5,
    RegViewport  = 3'd6
  } cfg_reg_e;

  // Input word: the point and the modelview pairs, first field in the top bits.
  typedef struct packed {
    logic signed [QW-1:0] obj_x;
    logic signed [QW-1:0] obj_y;
    logic signed [QW-1:0] obj_z;
    logic [0:7][63:0]     mv_pair;
  } vertex_word_t;

  // Result word, first field in the top bits.
  typedef struct packed {
    logic signed [QW-1:0] win_x;
    logic signed [QW-1:0] win_y;
    logic signed [QW-1:0] win_z;
    logic                 valid_res;
  } window_word_t;

  // Projection entries and viewport as the datapath sees them.
  typedef struct packed {
    logic signed [3:0][QW-1:0] row0;
    logic signed [3:0][QW-1:0] row1;
    logic signed [3:0][QW-1:0] row2;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] vw;
    logic [15:0] vh;
  } proj_cfg_t;

  // Clamp a wide signed value to a Q16.16 word.
  function automatic logic signed [QW-1:0] sat32(input logic signed [67:0] v);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    begin
      hi = 68'sh7FFFFFFF;
      lo = -68'sh80000000;
      if (v > hi) sat32 = 32'sh7FFFFFFF;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[QW-1:0];
    end
  endfunction

endpackage

/* hw/rtl/vwp_if.sv */
// Valid/ready channel interface carrying one payload word.
interface vwp_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/vertex_to_window_projection.sv */
// Top level of the vertex projector: configuration, pipeline control and viewport map.
// Pipeline: eye, clip, divide, map and output stages, in that order.
// Throughput: one word per cycle; the whole pipeline advances when the output stage is free.
// Reset: rst_ni clears all valid bits and all configuration registers to zero.
// A result held at the output stalls the whole pipeline, the input included.
module vertex_to_window_projection import vwp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  vwp_if.sink                 in_if,
  vwp_if.source               out_if
);
  localparam int unsigned Lat = 4 + DivStages + 3;

  proj_cfg_t cfg_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegProjCol0: begin
          cfg_q.row0[0] <= cfg_data_i[31:0];
          cfg_q.row1[0] <= cfg_data_i[63:32];
        end
        RegProjCol1: begin
          cfg_q.row0[1] <= cfg_data_i[31:0];
          cfg_q.row1[1] <= cfg_data_i[63:32];
        end
        RegProjCol2: begin
          cfg_q.row0[2] <= cfg_data_i[31:0];
          cfg_q.row1[2] <= cfg_data_i[63:32];
        end
        RegProjCol3: begin
          cfg_q.row0[3] <= cfg_data_i[31:0];
          cfg_q.row1[3] <= cfg_data_i[63:32];
        end
        RegProjRow2A: begin
          cfg_q.row2[0] <= cfg_data_i[31:0];
          cfg_q.row2[1] <= cfg_data_i[63:32];
        end
        RegProjRow2B: begin
          cfg_q.row2[2] <= cfg_data_i[31:0];
          cfg_q.row2[3] <= cfg_data_i[63:32];
        end
        RegViewport: begin
          cfg_q.vx <= cfg_data_i[15:0];  cfg_q.vy <= cfg_data_i[31:16];
          cfg_q.vw <= cfg_data_i[47:32]; cfg_q.vh <= cfg_data_i[63:48];
        end
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the output register can take a word.
  logic adv;
  logic [Lat-1:0] vld_q;
  assign adv = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Lat-2:0], in_if.valid};
  end

  // Eye coordinates from the modelview matrix.
  logic signed [3:0][QW-1:0] obj;
  logic signed [15:0][QW-1:0] mv;
  logic signed [3:0][QW-1:0] eye;
  assign obj = {32'sh00010000, in_if.data.obj_z, in_if.data.obj_y, in_if.data.obj_x};
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mv[2*i]   = in_if.data.mv_pair[i][31:0];
      mv[2*i+1] = in_if.data.mv_pair[i][63:32];
    end
  end
  for (genvar j = 0; j < 4; j++) begin : g_eye
    logic signed [3:0][QW-1:0] row;
    assign row = {mv[j+12], mv[j+8], mv[j+4], mv[j]};
    vwp_dot4 u_dot (.clk_i, .en_i(adv), .a_i(row), .b_i(obj), .sum_o(eye[j]));
  end

  // Clip coordinates; w travels alongside.
  logic signed [2:0][QW-1:0] clip;
  logic signed [QW:0] w0_q, w1_q;
  vwp_dot4 u_cx (.clk_i, .en_i(adv), .a_i(cfg_q.row0), .b_i(eye), .sum_o(clip[0]));
  vwp_dot4 u_cy (.clk_i, .en_i(adv), .a_i(cfg_q.row1), .b_i(eye), .sum_o(clip[1]));
  vwp_dot4 u_cz (.clk_i, .en_i(adv), .a_i(cfg_q.row2), .b_i(eye), .sum_o(clip[2]));
  always_ff @(posedge clk_i) begin
    if (adv) begin
      w0_q <= -(QW+1)'($signed(eye[2]));
      w1_q <= w0_q;
    end
  end

  // Division by w; zero flag delayed to match.
  logic signed [2:0][QW-1:0] ndc;
  logic [DivStages-1:0] wz_q;
  logic signed [QW:0] w_safe;
  assign w_safe = (w1_q == '0) ? (QW+1)'(1) : w1_q;
  for (genvar j = 0; j < 3; j++) begin : g_div
    vwp_div u_div (.clk_i, .en_i(adv), .num_i(clip[j]), .den_i(w_safe), .quo_o(ndc[j]));
  end
  always_ff @(posedge clk_i) begin
    if (adv) wz_q <= {wz_q[DivStages-2:0], (w1_q == '0)};
  end

  // Viewport map: add one, multiply, then floor-halve plus origin; z is only floor-halved after the add.
  logic signed [QW:0] nx_q, ny_q, nz_q;
  logic [2:0] wzm_q;
  logic signed [50:0] px_q, py_q;
  logic signed [QW-1:0] wx_q, wy_q, wz_o_q;
  logic signed [QW:0] nz2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q <= (QW+1)'($signed(ndc[0])) + 33'sh10000;
      ny_q <= (QW+1)'($signed(ndc[1])) + 33'sh10000;
      nz_q <= (QW+1)'($signed(ndc[2])) + 33'sh10000;
      wzm_q <= {wzm_q[1:0], wz_q[DivStages-1]};
      px_q <= nx_q * $signed({1'b0, cfg_q.vw});
      py_q <= ny_q * $signed({1'b0, cfg_q.vh});
      nz2_q <= nz_q;
      wx_q <= sat32(68'(px_q >>> 1) + 68'($signed({1'b0, cfg_q.vx, 16'h0000})));
      wy_q <= sat32(68'(py_q >>> 1) + 68'($signed({1'b0, cfg_q.vy, 16'h0000})));
      wz_o_q <= sat32(68'(nz2_q >>> 1));
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.valid <= 1'b0;
    else if (adv) out_if.valid <= vld_q[Lat-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_if.data.valid_res <= !wzm_q[2];
      out_if.data.win_x <= wzm_q[2] ? '0 : wx_q;
      out_if.data.win_y <= wzm_q[2] ? '0 : wy_q;
      out_if.data.win_z <= wzm_q[2] ? '0 : wz_o_q;
    end
  end
endmodule

/* hw/rtl/vwp_dot4.sv */
// Four-term Q16.16 dot product: products registered, then floored sum saturated.
module vwp_dot4 import vwp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [3:0][QW-1:0] a_i,
  input  logic signed [3:0][QW-1:0] b_i,
  output logic signed [QW-1:0]  sum_o
);
  logic signed [3:0][63:0] prod_q;
  logic signed [67:0] acc;

  // Stage one: the four exact products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) prod_q[k] <= $signed(a_i[k]) * $signed(b_i[k]);
    end
  end

  // Floor each product to Q16.16 and add exactly.
  always_comb begin
    acc = '0;
    for (int k = 0; k < 4; k++) acc = acc + 68'($signed(prod_q[k][63:16]));
  end

  // Stage two: the saturated sum.
  always_ff @(posedge clk_i) begin
    if (en_i) sum_o <= sat32(acc);
  end
endmodule

/* hw/rtl/vwp_div.sv */
// Pipelined signed divider: quotient of clip*65536 by w, truncated toward zero.
module vwp_div import vwp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [QW-1:0] num_i,
  input  logic signed [QW:0]   den_i,
  output logic signed [QW-1:0] quo_o
);
  // Dividend magnitude is at most 2^47, so 48 quotient bits, six per stage.
  localparam int unsigned NW = 48;
  localparam int unsigned DW = 33;
  localparam int unsigned BPS = NW / DivStages;

  logic [NW-1:0] n_q   [DivStages];
  logic [DW:0]   r_q   [DivStages];
  logic [DW-1:0] d_q   [DivStages];
  logic          neg_q [DivStages];

  logic [NW-1:0] num_mag;
  logic [DW-1:0] den_mag;
  logic signed [NW:0] num_ext;

  assign num_ext = {num_i[QW-1], num_i, 16'h0000};
  assign num_mag = num_ext[NW] ? NW'(-num_ext) : num_ext[NW-1:0];
  assign den_mag = den_i[QW] ? DW'(-den_i) : DW'(den_i);

  // Restoring division, six quotient bits per stage.
  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [NW-1:0] n_in;
    logic [DW:0]   r_in;
    logic [DW-1:0] d_in;
    logic          neg_in;
    logic [NW-1:0] n_c;
    logic [DW:0]   r_c;
    if (s == 0) begin : g_first
      assign n_in   = num_mag;
      assign r_in   = '0;
      assign d_in   = den_mag;
      assign neg_in = num_i[QW-1] ^ den_i[QW];
    end else begin : g_next
      assign n_in   = n_q[s-1];
      assign r_in   = r_q[s-1];
      assign d_in   = d_q[s-1];
      assign neg_in = neg_q[s-1];
    end
    always_comb begin
      n_c = n_in;
      r_c = r_in;
      for (int b = 0; b < BPS; b++) begin
        r_c = {r_c[DW-1:0], n_c[NW-1]};
        n_c = {n_c[NW-2:0], 1'b0};
        if (r_c >= {1'b0, d_in}) begin
          r_c = r_c - {1'b0, d_in};
          n_c[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s]   <= n_c;
        r_q[s]   <= r_c;
        d_q[s]   <= d_in;
        neg_q[s] <= neg_in;
      end
    end
  end

  logic signed [67:0] q_s;
  assign q_s = neg_q[DivStages-1] ? -68'($signed({1'b0, n_q[DivStages-1]}))
                                  : 68'($signed({1'b0, n_q[DivStages-1]}));
  assign quo_o = sat32(q_s);
endmodule

/* bench/tb_vertex_to_window_projection.sv */
// Testbench for the vertex projector: random and directed vertices checked against a predictor.
`timescale 1ns / 1ps

module tb_vertex_to_window_projection;
  import vwp_pkg::*;

  // An index with no register behind it.
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam longint QOne = 65536;
  localparam int DrainCycles = 40;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  vwp_if #(.payload_t(vertex_word_t)) in_if ();
  vwp_if #(.payload_t(window_word_t)) out_if ();

  vertex_to_window_projection uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if(in_if.sink),
    .out_if(out_if.source)
  );

  // Shadow copy of the configuration registers.
  logic [63:0] shadow_regs [0:6];

  vertex_word_t pending_vertices [$];
  window_word_t expected_windows [$];
  int errors = 0;
  int vertices_sent = 0;
  int windows_seen = 0;
  int invalid_seen = 0;
  bit in_fire = 0;
  bit calm = 0;
  bit stall_req = 0;
  bit stall_done = 0;
  int stall_left = 0;

  // Clock.
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint word_s(logic [31:0] w);
    return longint'(signed'(w));
  endfunction

  // Sum of four floored Q16.16 products, clamped.
  function automatic longint dot_q(longint a [4], longint b [4]);
    longint s;
    s = 0;
    for (int k = 0; k < 4; k++) s += (a[k] * b[k]) >>> 16;
    return clamp32(s);
  endfunction

  function automatic longint view_map(longint ndc, longint size, longint origin);
    return clamp32((((ndc + QOne) * size) >>> 1) + origin * QOne);
  endfunction

  // Projects one vertex with the current shadow configuration.
  function automatic window_word_t project_vertex(vertex_word_t v);
    longint mv [16];
    longint pr [16];
    longint obj [4];
    longint eye [4];
    longint row [4];
    longint clip [3];
    longint ndc [3];
    longint w;
    logic [63:0] vp;
    window_word_t r;
    for (int i = 0; i < 8; i++) begin
      mv[2*i] = word_s(v.mv_pair[i][31:0]);
      mv[2*i+1] = word_s(v.mv_pair[i][63:32]);
    end
    for (int i = 0; i < 16; i++) pr[i] = 0;
    pr[0] = word_s(shadow_regs[RegProjCol0][31:0]);
    pr[1] = word_s(shadow_regs[RegProjCol0][63:32]);
    pr[4] = word_s(shadow_regs[RegProjCol1][31:0]);
    pr[5] = word_s(shadow_regs[RegProjCol1][63:32]);
    pr[8] = word_s(shadow_regs[RegProjCol2][31:0]);
    pr[9] = word_s(shadow_regs[RegProjCol2][63:32]);
    pr[12] = word_s(shadow_regs[RegProjCol3][31:0]);
    pr[13] = word_s(shadow_regs[RegProjCol3][63:32]);
    pr[2] = word_s(shadow_regs[RegProjRow2A][31:0]);
    pr[6] = word_s(shadow_regs[RegProjRow2A][63:32]);
    pr[10] = word_s(shadow_regs[RegProjRow2B][31:0]);
    pr[14] = word_s(shadow_regs[RegProjRow2B][63:32]);
    obj[0] = word_s(v.obj_x);
    obj[1] = word_s(v.obj_y);
    obj[2] = word_s(v.obj_z);
    obj[3] = QOne;
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) row[i] = mv[j+4*i];
      eye[j] = dot_q(row, obj);
    end
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 4; i++) row[i] = pr[j+4*i];
      clip[j] = dot_q(row, eye);
    end
    w = -eye[2];
    r = '0;
    if (w == 0) return r;
    for (int j = 0; j < 3; j++) ndc[j] = clamp32((clip[j] * QOne) / w);
    vp = shadow_regs[RegViewport];
    r.win_x = 32'(view_map(ndc[0], longint'(vp[47:32]), longint'(vp[15:0])));
    r.win_y = 32'(view_map(ndc[1], longint'(vp[63:48]), longint'(vp[31:16])));
    r.win_z = 32'(clamp32((QOne + ndc[2]) >>> 1));
    r.valid_res = 1'b1;
    return r;
  endfunction

  // Input acceptance: predict each accepted vertex.
  always @(posedge clk_i) begin
    in_fire = in_if.valid && in_if.ready;
    if (in_fire) begin
      expected_windows = {expected_windows, project_vertex(in_if.data)};
      vertices_sent++;
    end
  end

  // Driver: offers the next pending vertex, idling at random.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end else if (!in_if.valid || in_fire) begin
      if (pending_vertices.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
        in_if.data <= pending_vertices.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_done <= 1'b1;
      stall_left <= 200;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= 36);
    end
  end

  // Monitor: compares each result word with the oldest prediction.
  always @(posedge clk_i) begin
    window_word_t exp_w;
    window_word_t got;
    if (out_if.valid && out_if.ready) begin
      got = out_if.data;
      windows_seen++;
      if (!got.valid_res) invalid_seen++;
      if (expected_windows.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, got);
      end else begin
        exp_w = expected_windows.pop_front();
        if (got.win_x !== exp_w.win_x) begin
          errors++;
          $display("%0t: win_x expected %h actual %h", $time, exp_w.win_x, got.win_x);
        end
        if (got.win_y !== exp_w.win_y) begin
          errors++;
          $display("%0t: win_y expected %h actual %h", $time, exp_w.win_y, got.win_y);
        end
        if (got.win_z !== exp_w.win_z) begin
          errors++;
          $display("%0t: win_z expected %h actual %h", $time, exp_w.win_z, got.win_z);
        end
        if (got.valid_res !== exp_w.valid_res) begin
          errors++;
          $display("%0t: valid_res expected %b actual %b", $time, exp_w.valid_res,
                   got.valid_res);
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= RegViewport) shadow_regs[idx] = value;
  endtask

  // Appends one vertex to the pending queue.
  task automatic add_vertex(vertex_word_t v);
    pending_vertices = {pending_vertices, v};
  endtask

  // Waits until every vertex has gone in and every result has come out.
  task automatic drain();
    while (pending_vertices.size() > 0 || in_if.valid || expected_windows.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_q(int unsigned span);
    return 32'($signed($urandom_range(2 * span)) - $signed(span));
  endfunction

  // A plausible modelview: small rotation part, modest translation, eye z mostly negative.
  function automatic vertex_word_t sane_vertex();
    vertex_word_t v;
    logic [31:0] e [16];
    for (int i = 0; i < 16; i++) e[i] = rand_q(2 * 65536);
    e[12] = rand_q(8 * 65536);
    e[13] = rand_q(8 * 65536);
    e[14] = -(32'($urandom_range(20 * 65536)) + 32'd65536);
    e[3] = '0; e[7] = '0; e[11] = '0; e[15] = 32'd65536;
    if ($urandom_range(9) == 0) begin
      // Drop the z row so that w comes out zero.
      e[2] = '0; e[6] = '0; e[10] = '0; e[14] = '0;
    end
    for (int i = 0; i < 8; i++) v.mv_pair[i] = {e[2*i+1], e[2*i]};
    v.obj_x = rand_q(16 * 65536);
    v.obj_y = rand_q(16 * 65536);
    v.obj_z = rand_q(16 * 65536);
    return v;
  endfunction

  function automatic vertex_word_t noise_vertex();
    vertex_word_t v;
    for (int i = 0; i < 8; i++) v.mv_pair[i] = rand64();
    v.obj_x = $urandom;
    v.obj_y = $urandom;
    v.obj_z = $urandom;
    return v;
  endfunction

  function automatic vertex_word_t fill_vertex(logic [31:0] o, logic [31:0] m);
    vertex_word_t v;
    v.obj_x = o; v.obj_y = o; v.obj_z = o;
    for (int i = 0; i < 8; i++) v.mv_pair[i] = {m, m};
    return v;
  endfunction

  // Identity modelview with eye z shifted by tz.
  function automatic vertex_word_t ident_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                                logic [31:0] tz);
    vertex_word_t v;
    v = fill_vertex('0, '0);
    v.obj_x = x; v.obj_y = y; v.obj_z = z;
    v.mv_pair[0] = {32'd0, 32'd65536};
    v.mv_pair[2] = {32'd65536, 32'd0};
    v.mv_pair[5] = {32'd0, 32'd65536};
    v.mv_pair[7] = {32'd65536, tz};
    return v;
  endfunction

  task automatic load_setting(int s);
    logic [63:0] vals [7];
    case (s)
      0: for (int i = 0; i < 7; i++) vals[i] = '0;
      1: begin
        // Ordinary perspective, 640 by 480 viewport at (16, 8).
        vals[0] = {32'd0, 32'd65536 * 2};
        vals[1] = {32'd65536 * 2, 32'd0};
        vals[2] = {32'hFFFF_0000, 32'd0};
        vals[3] = '0;
        vals[4] = '0;
        vals[5] = {32'hFFFE_0000, 32'hFFFE_C000};
        vals[6] = {16'd480, 16'd640, 16'd8, 16'd16};
      end
      2: for (int i = 0; i < 7; i++) vals[i] = '1;
      3: for (int i = 0; i < 7; i++) vals[i] = 64'h7FFF_FFFF_7FFF_FFFF;
      4: for (int i = 0; i < 7; i++) vals[i] = 64'h8000_0000_8000_0000;
      default: begin
        for (int i = 0; i < 6; i++)
          vals[i] = {rand_q(3 * 65536), rand_q(3 * 65536)};
        vals[6] = rand64();
      end
    endcase
    for (int i = 0; i < 7; i++) write_reg(CfgIdxW'(i), vals[i]);
    // The spare index must leave every register alone.
    write_reg(RegUnused, rand64());
  endtask

  // Stimulus sequence.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    for (int i = 0; i < 7; i++) shadow_regs[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (5) @(posedge clk_i);

    for (int s = 0; s < 7; s++) begin
      if (s > 0) load_setting(s);
      calm = (s == 3);
      if (s == 1) begin
        // Directed vertices: zero w, field extremes, plain points.
        add_vertex(fill_vertex('0, '0));
        add_vertex(ident_vertex('0, '0, '0, '0));
        add_vertex(ident_vertex(32'd65536, 32'd65536, '0, 32'hFFFF_0000));
        add_vertex(ident_vertex(32'hFFFF_0000, 32'd32768, 32'hFFFE_0000, '0));
        add_vertex(ident_vertex(32'h7FFF_FFFF, 32'h8000_0000, '0, 32'hFFFF_FFFF));
        add_vertex(ident_vertex('0, '0, 32'h7FFF_FFFF, 32'h8000_0000));
        add_vertex(ident_vertex('0, '0, 32'd1, '0));
        add_vertex(fill_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_vertex(fill_vertex(32'h8000_0000, 32'h8000_0000));
        add_vertex(fill_vertex(32'h8000_0000, 32'h7FFF_FFFF));
        add_vertex(fill_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_vertex(fill_vertex(32'd65536, 32'd65536));
      end
      if (s == 2) stall_req = 1'b1;
      for (int n = 0; n < 100; n++)
        add_vertex($urandom_range(3) == 0 ? noise_vertex() : sane_vertex());
      // Sender pauses here until every result of the phase is back.
      drain();
    end

    $display("Covered %0d vertices over seven register settings, %0d of them with zero w.",
             vertices_sent, invalid_seen);
    if (errors == 0 && expected_windows.size() == 0) begin
      $display("vertex_to_window_projection verification clean");
    end else begin
      $display("vertex_to_window_projection verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("vertex_to_window_projection verification failed");
    $finish;
  end

endmodule
